FILE: hw/rtl/fbpa_pkg.sv
// fbpa_pkg: shared types, codes and constants of the fixed block pool allocator
// no dependencies; used by every module of the block but fbpa_ram
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int POOL_DEPTH_DEF = 4096;

    // fixed field widths
    localparam int IDX_W    = 12;
    localparam int BLK_W    = 13;  // width of block counts and of a fresh index
    localparam int BASE_W   = 33;  // aligned base may carry into bit 32
    localparam int SIZE_W   = 14;  // aligned block size, up to 8192
    localparam int PROD_W   = BLK_W + SIZE_W;
    localparam int CDATA_W  = 32;
    localparam int CIDX_W   = 2;

    localparam logic [BLK_W-1:0] POOL_BLOCKS_RST = 13'd4096;
    localparam logic [SIZE_W-1:0] SIZE_MIN       = 14'd16;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_POOL_BLOCKS = 2'd2;

    // operations
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] freed_index;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  block_index;
        logic [BASE_W-1:0] block_address;
    } rsp_t;

    // derived configuration, computed when a register is written
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [BLK_W-1:0]  limit;
    } cfg_t;

    // decided item handed from queue control to the address stage
    typedef struct packed {
        logic [1:0]       status;
        logic [BLK_W-1:0] idx;
    } item_t;

    typedef enum logic {
        S_IDLE,
        S_ISSUE
    } ctrl_state_t;

endpackage

FILE: hw/rtl/fixed_block_pool_allocator_unit.sv
// fixed_block_pool_allocator_unit: top level, configuration registers and wiring
// depends on fbpa_pkg, fbpa_queue_ctrl, fbpa_addr_unit
`timescale 1ns / 1ps

// Allocates and returns fixed-size blocks of a pool. An allocate item takes the
// oldest returned block from a ring of freed indices held in a block ram, or the
// next never-used block when the ring is empty, and reports exhaustion once the
// pool is used up. A return item is range-checked and, unless the ring is full,
// appended to the ring. Every item yields one result: status, block index and
// base + index * aligned size (zero when exhausted). The free queue ram is read
// at accept; the index-by-size product is then registered and the base add lands
// in the result register. A new item is accepted once the last is in the product
// register, even while a result waits in its output register. Configuration
// registers must be written only while idle; the block does not enforce this.
// The free queue needs no clearing after reset: only written entries are read.

module fixed_block_pool_allocator_unit #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [fbpa_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::CDATA_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fbpa_pkg::req_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fbpa_pkg::rsp_t                out_data
);

    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W = (CNT_W > fbpa_pkg::BLK_W) ? CNT_W : fbpa_pkg::BLK_W;
    localparam logic [CMP_W-1:0] MAX_V = CMP_W'(POOL_DEPTH);
    localparam logic [fbpa_pkg::BLK_W-1:0] LIMIT_RST =
        (CMP_W'(fbpa_pkg::POOL_BLOCKS_RST) < MAX_V) ? fbpa_pkg::POOL_BLOCKS_RST
                                                     : fbpa_pkg::BLK_W'(POOL_DEPTH);

    fbpa_pkg::cfg_t cfg_reg;

    logic [fbpa_pkg::BASE_W-1:0] base_aligned;
    logic [fbpa_pkg::SIZE_W-1:0] size_round;
    logic [fbpa_pkg::SIZE_W-1:0] size_aligned;
    logic [fbpa_pkg::BLK_W-1:0]  blocks_wr;
    logic [fbpa_pkg::BLK_W-1:0]  limit_wr;

    logic            item_valid;
    logic            item_ready;
    fbpa_pkg::item_t item;

    // derived values kept instead of the raw register contents
    always_comb
    begin
        base_aligned = ({1'b0, cfg_data} + fbpa_pkg::BASE_W'(7)) & ~fbpa_pkg::BASE_W'(7);
        size_round   = ({1'b0, cfg_data[fbpa_pkg::BLK_W-1:0]} + fbpa_pkg::SIZE_W'(7))
                       & ~fbpa_pkg::SIZE_W'(7);
        size_aligned = (size_round < fbpa_pkg::SIZE_MIN) ? fbpa_pkg::SIZE_MIN : size_round;
        blocks_wr    = cfg_data[fbpa_pkg::BLK_W-1:0];
        limit_wr     = (CMP_W'(blocks_wr) < MAX_V) ? blocks_wr : fbpa_pkg::BLK_W'(POOL_DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base  <= '0;
            cfg_reg.size  <= fbpa_pkg::SIZE_MIN;
            cfg_reg.limit <= LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fbpa_pkg::CFG_POOL_BASE:   cfg_reg.base  <= base_aligned;
                fbpa_pkg::CFG_BLOCK_BYTES: cfg_reg.size  <= size_aligned;
                fbpa_pkg::CFG_POOL_BLOCKS: cfg_reg.limit <= limit_wr;
                default:                   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    fbpa_queue_ctrl #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_queue_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item)
    );

    fbpa_addr_unit u_addr_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: hw/rtl/fbpa_ram.sv
// fbpa_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/fbpa_queue_ctrl.sv
// fbpa_queue_ctrl: free queue ring, bump counter and request decision
// depends on fbpa_pkg and fbpa_ram
`timescale 1ns / 1ps

module fbpa_queue_ctrl #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fbpa_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  fbpa_pkg::req_t      in_data,
    output logic                item_valid,
    input  logic                item_ready,
    output fbpa_pkg::item_t     item
);

    localparam int PTR_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W = (CNT_W > fbpa_pkg::BLK_W) ? CNT_W : fbpa_pkg::BLK_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POOL_DEPTH - 1);

    fbpa_pkg::ctrl_state_t state_reg, state_next;

    logic [PTR_W-1:0]          head_reg, head_next;
    logic [PTR_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [fbpa_pkg::BLK_W-1:0] fresh_reg, fresh_next;

    logic                       from_queue_reg;
    logic [1:0]                 status_reg;
    logic [fbpa_pkg::BLK_W-1:0] idx_reg;

    logic                       accept;
    logic                       pop;
    logic                       push;
    logic                       fresh_ok;
    logic                       queue_empty;
    logic [fbpa_pkg::BLK_W-1:0] freed_ext;
    logic [1:0]                 status_dec;
    logic [fbpa_pkg::BLK_W-1:0] idx_dec;
    logic [fbpa_pkg::IDX_W-1:0] rd_data;

    assign accept      = in_valid && in_ready;
    assign queue_empty = (count_reg == '0);
    assign freed_ext   = {1'b0, in_data.freed_index};
    assign fresh_ok    = fresh_reg < cfg.limit;

    // decide the item at accept
    always_comb
    begin
        pop        = 1'b0;
        push       = 1'b0;
        status_dec = fbpa_pkg::ST_OK;
        idx_dec    = freed_ext;
        if (in_data.operation == fbpa_pkg::OP_ALLOC)
        begin
            priority if (!queue_empty)
            begin
                pop = accept;
            end
            else if (fresh_ok)
            begin
                idx_dec = fresh_reg;
            end
            else
            begin
                status_dec = fbpa_pkg::ST_EXHAUSTED;
                idx_dec    = '0;
            end
        end
        else
        begin
            priority if (freed_ext >= cfg.limit)
            begin
                status_dec = fbpa_pkg::ST_RANGE;
            end
            else if (CMP_W'(count_reg) >= CMP_W'(cfg.limit))
            begin
                status_dec = fbpa_pkg::ST_FULL;
            end
            else
            begin
                push = accept;
            end
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        fresh_next = fresh_reg;
        if (pop)
        begin
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (push)
        begin
            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (accept && in_data.operation == fbpa_pkg::OP_ALLOC && queue_empty && fresh_ok)
        begin
            fresh_next = fresh_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = fbpa_pkg::S_ISSUE;
                end
            end
            fbpa_pkg::S_ISSUE:
            begin
                if (item_ready)
                begin
                    state_next = fbpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    // outputs; ram read data stays put while the item waits
    always_comb
    begin
        in_ready   = 1'b0;
        item_valid = 1'b0;
        unique case (state_reg)
            fbpa_pkg::S_IDLE:  in_ready   = 1'b1;
            fbpa_pkg::S_ISSUE: item_valid = 1'b1;
            default:           in_ready   = 1'b0;
        endcase
        item.status = status_reg;
        item.idx    = from_queue_reg ? {1'b0, rd_data} : idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbpa_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            from_queue_reg <= pop;
            status_reg     <= status_dec;
            idx_reg        <= idx_dec;
        end
    end

    fbpa_ram #(
        .WIDTH (fbpa_pkg::IDX_W),
        .DEPTH (POOL_DEPTH),
        .ADDR_W(PTR_W)
    ) u_free_queue (
        .clk    (clk),
        .wr_en  (push),
        .wr_addr(tail_reg),
        .wr_data(in_data.freed_index),
        .rd_en  (pop),
        .rd_addr(head_reg),
        .rd_data(rd_data)
    );

endmodule

FILE: hw/rtl/fbpa_addr_unit.sv
// fbpa_addr_unit: block address multiply-add and result register
// depends on fbpa_pkg
`timescale 1ns / 1ps

module fbpa_addr_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  fbpa_pkg::cfg_t  cfg,
    input  logic            item_valid,
    output logic            item_ready,
    input  fbpa_pkg::item_t item,
    output logic            out_valid,
    input  logic            out_ready,
    output fbpa_pkg::rsp_t  out_data
);

    logic                        mul_valid_reg;
    logic [1:0]                  mul_status_reg;
    logic [fbpa_pkg::IDX_W-1:0]  mul_idx_reg;
    logic [fbpa_pkg::PROD_W-1:0] mul_prod_reg;

    logic                        out_valid_reg;
    fbpa_pkg::rsp_t              out_data_reg;

    logic                        out_load;
    logic                        mul_load;
    logic [fbpa_pkg::BASE_W-1:0] sum;

    assign out_load   = mul_valid_reg && (!out_valid_reg || out_ready);
    assign item_ready = !mul_valid_reg || out_load;
    assign mul_load   = item_valid && item_ready;

    assign sum = cfg.base + fbpa_pkg::BASE_W'(mul_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_load)
            begin
                mul_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                mul_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            mul_status_reg <= item.status;
            mul_idx_reg    <= item.idx[fbpa_pkg::IDX_W-1:0];
            mul_prod_reg   <= item.idx * cfg.size;
        end
        if (out_load)
        begin
            out_data_reg.status        <= mul_status_reg;
            out_data_reg.block_index   <= mul_idx_reg;
            // exhausted allocations report a zero address
            out_data_reg.block_address <=
                (mul_status_reg == fbpa_pkg::ST_EXHAUSTED) ? '0 : sum;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for fixed_block_pool_allocator_unit
// depends on fbpa_pkg and the allocator rtl; keeps its own model of the free ring and counters
`timescale 1ns / 1ps

module tb_top;

    localparam int POOL_MAX = fbpa_pkg::POOL_DEPTH_DEF;
    localparam int CW = fbpa_pkg::CIDX_W;
    localparam int DW = fbpa_pkg::CDATA_W;
    localparam int BW = fbpa_pkg::BLK_W;
    localparam int IW = fbpa_pkg::IDX_W;
    localparam int AW = fbpa_pkg::BASE_W;
    localparam int SW = fbpa_pkg::SIZE_W;
    localparam logic [CW-1:0] CFG_SPARE = 2'd3;   // unmapped register index
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 1400;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [CW-1:0]      cfg_index;
    logic [DW-1:0]      cfg_data;
    logic               in_valid;
    logic               in_ready;
    fbpa_pkg::req_t     in_data;
    logic               out_valid;
    logic               out_ready;
    fbpa_pkg::rsp_t     out_data;

    fixed_block_pool_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // allocator state as the testbench sees it
    logic [31:0]   pool_base_reg;
    logic [BW-1:0] block_bytes_reg;
    logic [BW-1:0] pool_blocks_reg;
    logic [IW-1:0] freed_ring[$];
    logic [BW-1:0] fresh_next;

    fbpa_pkg::rsp_t pending_rsp[$];
    logic [IW-1:0]  held_blocks[$];   // handed out and not yet returned
    logic [IW-1:0]  last_freed;

    bit gaps_on;
    int stall_left;
    int idle_cycles;
    int errors;
    int n_alloc;
    int n_free;
    int n_settings;
    int status_seen[4];

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [BW-1:0] pool_limit_now();
        return (pool_blocks_reg > POOL_MAX) ? BW'(POOL_MAX) : pool_blocks_reg;
    endfunction

    function automatic logic [AW-1:0] block_address_of(logic [IW-1:0] idx);
        logic [AW-1:0] base;
        logic [SW-1:0] bsize;
        base  = ({1'b0, pool_base_reg} + 33'd7) & ~33'd7;
        bsize = ({1'b0, block_bytes_reg} + 14'd7) & ~14'd7;
        if (bsize < 14'd16)
            bsize = 14'd16;
        return base + AW'(idx) * AW'(bsize);
    endfunction

    // computes the result of one request and advances the ring and the bump counter
    function automatic fbpa_pkg::rsp_t allocator_response(fbpa_pkg::req_t r);
        logic [BW-1:0] lim;
        fbpa_pkg::rsp_t o;
        lim = pool_limit_now();
        if (r.operation == fbpa_pkg::OP_ALLOC)
        begin
            if (freed_ring.size() != 0)
            begin
                o.block_index   = freed_ring.pop_front();
                o.status        = fbpa_pkg::ST_OK;
                o.block_address = block_address_of(o.block_index);
            end
            else if (fresh_next < lim)
            begin
                o.block_index   = fresh_next[IW-1:0];
                fresh_next      = fresh_next + 1'b1;
                o.status        = fbpa_pkg::ST_OK;
                o.block_address = block_address_of(o.block_index);
            end
            else
            begin
                o.block_index   = '0;
                o.status        = fbpa_pkg::ST_EXHAUSTED;
                o.block_address = '0;
            end
        end
        else
        begin
            o.block_index   = r.freed_index;
            o.block_address = block_address_of(r.freed_index);
            if ({1'b0, r.freed_index} >= lim)
                o.status = fbpa_pkg::ST_RANGE;
            else if (freed_ring.size() >= lim)
                o.status = fbpa_pkg::ST_FULL;
            else
            begin
                freed_ring.push_back(r.freed_index);
                o.status = fbpa_pkg::ST_OK;
            end
        end
        return o;
    endfunction

    function automatic int short_or_long_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // leaves cfg_write high so that writes can follow back to back
    task automatic write_register(logic [CW-1:0] idx, logic [DW-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            fbpa_pkg::CFG_POOL_BASE:   pool_base_reg   = data;
            fbpa_pkg::CFG_BLOCK_BYTES: block_bytes_reg = data[BW-1:0];
            fbpa_pkg::CFG_POOL_BLOCKS: pool_blocks_reg = data[BW-1:0];
            default: ;
        endcase
    endtask

    task automatic end_register_writes();
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    task automatic set_pool(logic [31:0] base, logic [DW-1:0] bytes,
                            logic [DW-1:0] blocks);
        write_register(fbpa_pkg::CFG_POOL_BASE, base);
        write_register(fbpa_pkg::CFG_BLOCK_BYTES, bytes);
        write_register(fbpa_pkg::CFG_POOL_BLOCKS, blocks);
        end_register_writes();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_request(logic op, logic [IW-1:0] fidx);
        int gap;
        fbpa_pkg::req_t r;
        fbpa_pkg::rsp_t want;
        r.operation   = op;
        r.freed_index = fidx;
        gap = 0;
        if (gaps_on && $urandom_range(0, 99) >= 55)
            gap = short_or_long_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        want = allocator_response(r);
        pending_rsp.push_back(want);
        if (op == fbpa_pkg::OP_ALLOC)
        begin
            n_alloc++;
            if (want.status == fbpa_pkg::ST_OK)
                held_blocks.push_back(want.block_index);
        end
        else
        begin
            n_free++;
            last_freed = fidx;
        end
    endtask

    task automatic report_mismatch(string what, fbpa_pkg::rsp_t want, fbpa_pkg::rsp_t got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t mismatch (%s): expected st=%0d idx=%0d addr=%h, got st=%0d idx=%0d addr=%h",
                     $realtime, what, want.status, want.block_index, want.block_address,
                     got.status, got.block_index, got.block_address);
    endtask

    // ------------------------------------------------------------------ tests

    task automatic test_reset_config();
        wait_idle();
        send_request(fbpa_pkg::OP_ALLOC, 12'hfff);
        send_request(fbpa_pkg::OP_ALLOC, 12'h000);
        send_request(fbpa_pkg::OP_FREE, 12'd4095);
        send_request(fbpa_pkg::OP_FREE, 12'd0);
        send_request(fbpa_pkg::OP_ALLOC, 12'h555);
        send_request(fbpa_pkg::OP_ALLOC, 12'haaa);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        // base rounds up across bit 32, largest block size
        set_pool(32'hffff_ffff, 32'h0000_1fff, 32'h0000_1fff);
        send_request(fbpa_pkg::OP_FREE, 12'd4095);
        send_request(fbpa_pkg::OP_ALLOC, 12'd0);
        wait_idle();
        // size below the minimum is raised to 16
        set_pool(32'h0, 32'h0, 32'd4096);
        send_request(fbpa_pkg::OP_ALLOC, 12'd0);
    endtask

    task automatic test_unmapped_register();
        wait_idle();
        write_register(CFG_SPARE, 32'hffff_ffff);
        end_register_writes();
        send_request(fbpa_pkg::OP_ALLOC, 12'hfff);
    endtask

    task automatic test_empty_pool();
        wait_idle();
        set_pool(32'h0, 32'd16, 32'd0);
        send_request(fbpa_pkg::OP_ALLOC, 12'd0);
        send_request(fbpa_pkg::OP_FREE, 12'd0);
        send_request(fbpa_pkg::OP_FREE, 12'd4095);
    endtask

    task automatic test_exhaust_and_full();
        wait_idle();
        set_pool(32'd5, 32'd1, 32'd5);
        send_request(fbpa_pkg::OP_ALLOC, 12'd0);
        send_request(fbpa_pkg::OP_ALLOC, 12'd0);
        // repeated returns of one block fill the ring
        repeat (5) send_request(fbpa_pkg::OP_FREE, 12'd4);
        send_request(fbpa_pkg::OP_FREE, 12'd0);
        send_request(fbpa_pkg::OP_FREE, 12'd5);
    endtask

    task automatic test_shrunken_pool();
        wait_idle();
        // ring entries beyond the new size still come out, then the bump counter is past the end
        set_pool(32'h1234_5679, 32'd4096, 32'd2);
        repeat (6) send_request(fbpa_pkg::OP_ALLOC, 12'd0);
    endtask

    task automatic pick_random_setting();
        logic [DW-1:0] noise;
        logic [DW-1:0] base;
        logic [DW-1:0] bytes;
        logic [DW-1:0] blocks;
        noise = ($urandom_range(0, 1) != 0) ? ($urandom & 32'hffff_e000) : 32'h0;
        case ($urandom_range(0, 3))
            0: base = 32'h0;
            1: base = 32'hffff_ffff;
            default: base = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: bytes = $urandom;
            1: bytes = 32'd16;
            2: bytes = $urandom_range(1, 4096);
            3: bytes = 32'h1fff;
            default: bytes = $urandom_range(0, 15);
        endcase
        case ($urandom_range(0, 5))
            0, 1, 2: blocks = $urandom_range(1, 24);
            3: blocks = 32'd0;
            4: blocks = $urandom_range(4096, 8191);
            default: blocks = $urandom_range(25, 600);
        endcase
        if ($urandom_range(0, 4) == 0)
            write_register(CFG_SPARE, $urandom);
        write_register(fbpa_pkg::CFG_POOL_BASE, base);
        write_register(fbpa_pkg::CFG_BLOCK_BYTES, bytes | noise);
        write_register(fbpa_pkg::CFG_POOL_BLOCKS, blocks | noise);
        end_register_writes();
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int roll;
        int pick;
        logic [BW-1:0] lim;
        logic [IW-1:0] idx;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            pick_random_setting();
            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(80, 220);
            repeat (phase_len)
            begin
                lim  = pool_limit_now();
                roll = $urandom_range(0, 99);
                // lean toward allocation while the ring cannot take more
                if (roll < 45 || (freed_ring.size() >= lim && roll < 80))
                    send_request(fbpa_pkg::OP_ALLOC, IW'($urandom));
                else if (roll < 85 && held_blocks.size() != 0)
                begin
                    pick = $urandom_range(0, held_blocks.size() - 1);
                    idx  = held_blocks[pick];
                    held_blocks.delete(pick);
                    send_request(fbpa_pkg::OP_FREE, idx);
                end
                else if (roll < 92)
                    send_request(fbpa_pkg::OP_FREE, IW'($urandom));
                else if (roll < 96)
                    send_request(fbpa_pkg::OP_FREE, last_freed);
                else
                    send_request(fbpa_pkg::OP_FREE, IW'(lim - $urandom_range(0, 1)));
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------ sink side

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!gaps_on || $urandom_range(0, 99) >= 20)
            out_ready <= 1'b1;
        else
        begin
            stall_left = short_or_long_gap() - 1;
            out_ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        fbpa_pkg::rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            status_seen[out_data.status]++;
            if (pending_rsp.size() == 0)
                report_mismatch("nothing pending", '0, out_data);
            else
            begin
                want = pending_rsp.pop_front();
                if (out_data.status !== want.status
                    || out_data.block_index !== want.block_index
                    || out_data.block_address !== want.block_address)
                    report_mismatch("field", want, out_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_rsp.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = fbpa_pkg::CFG_POOL_BASE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        pool_base_reg   = 32'h0;
        block_bytes_reg = 13'd16;
        pool_blocks_reg = fbpa_pkg::POOL_BLOCKS_RST;
        fresh_next      = '0;
        last_freed      = '0;
        gaps_on     = 1'b1;
        stall_left  = 0;
        idle_cycles = 0;
        errors      = 0;
        n_alloc     = 0;
        n_free      = 0;
        n_settings  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_register_extremes();
        test_unmapped_register();
        test_empty_pool();
        test_exhaust_and_full();
        test_shrunken_pool();
        test_random_traffic();

        wait_idle();
        if (pending_rsp.size() != 0)
            errors += pending_rsp.size();
        $display("covered %0d requests (%0d allocate, %0d return) across %0d register settings",
                 n_alloc + n_free, n_alloc, n_free, n_settings);
        $display("statuses seen: ok %0d, exhausted %0d, out of range %0d, ring full %0d; %0d errors",
                 status_seen[fbpa_pkg::ST_OK], status_seen[fbpa_pkg::ST_EXHAUSTED],
                 status_seen[fbpa_pkg::ST_RANGE], status_seen[fbpa_pkg::ST_FULL], errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
